// ===== src/crc16mw_pkg.sv =====
// ----------------------------------------------------------------------------
// crc16mw_pkg
// Shared types, codes and bit-manipulation functions for the mixed-width
// CRC-16 unit.
// ----------------------------------------------------------------------------
package crc16mw_pkg;

  // Width of the CRC register and of the generator polynomial.
  localparam int CRC_BITS  = 16;
  localparam int DATA_BITS = 32;

  // Reset values of the configuration registers (CRC-16/MODBUS).
  localparam logic [CRC_BITS-1:0] POLY_RESET = 16'h8005;
  localparam logic [CRC_BITS-1:0] INIT_RESET = 16'hFFFF;
  localparam logic                REFL_RESET = 1'b1;

  typedef logic [CRC_BITS-1:0]  crc_t;
  typedef logic [DATA_BITS-1:0] data_t;

  // Feed width codes; the unused code behaves as a 32-bit feed.
  typedef enum logic [1:0] {
    FEED_8  = 2'd0,
    FEED_16 = 2'd1,
    FEED_32 = 2'd2
  } feed_width_t;

  // Input bit-reversal modes.
  typedef enum logic [1:0] {
    REV_NONE = 2'd0,
    REV_BYTE = 2'd1,
    REV_HALF = 2'd2,
    REV_WORD = 2'd3
  } reverse_mode_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_POLYNOMIAL     = 2'd0,
    REG_INITIAL_VALUE  = 2'd1,
    REG_OUTPUT_REFLECT = 2'd2
  } reg_index_t;

  // One input word as held in the input register.
  typedef struct packed {
    data_t      data_word;
    logic [1:0] feed_width;
    logic [1:0] reverse_mode;
    logic       first_item;
    logic       last_item;
  } item_t;

  // Control from the pipeline to the CRC engine.
  typedef struct packed {
    logic go;
    logic first_item;
  } eng_ctl_t;

  // Reverse the bit order of a whole CRC value.
  function automatic crc_t reflect_crc(input crc_t v);
    crc_t r;
    for (int i = 0; i < CRC_BITS; i++) begin
      r[i] = v[CRC_BITS-1-i];
    end
    return r;
  endfunction

  // Reverse each byte of a 32-bit word in place.
  function automatic data_t rev_bytes(input data_t v);
    data_t r;
    for (int i = 0; i < DATA_BITS; i++) begin
      r[i] = v[(i / 8) * 8 + 7 - (i % 8)];
    end
    return r;
  endfunction

  // Reverse each halfword of a 32-bit word in place.
  function automatic data_t rev_halves(input data_t v);
    data_t r;
    for (int i = 0; i < DATA_BITS; i++) begin
      r[i] = v[(i / 16) * 16 + 15 - (i % 16)];
    end
    return r;
  endfunction

  // Reverse the whole 32-bit word.
  function automatic data_t rev_word(input data_t v);
    data_t r;
    for (int i = 0; i < DATA_BITS; i++) begin
      r[i] = v[DATA_BITS-1-i];
    end
    return r;
  endfunction

endpackage

// ===== src/crc16mw_prep.sv =====
// ----------------------------------------------------------------------------
// crc16mw_prep
// Masks a word to its fed width, applies the input bit reversal and left
// aligns the fed bits so that the first bit to enter the CRC is bit 31.
// ----------------------------------------------------------------------------
module crc16mw_prep (
  input  crc16mw_pkg::data_t data_word,
  input  logic [1:0]         feed_width,
  input  logic [1:0]         reverse_mode,
  output crc16mw_pkg::data_t aligned,
  output logic [5:0]         nbits
);

  crc16mw_pkg::data_t masked;
  crc16mw_pkg::data_t reversed;

  // Keep only the fed bits and set the bit count.
  always_comb begin
    case (feed_width)
      crc16mw_pkg::FEED_8: begin
        masked = {24'd0, data_word[7:0]};
        nbits  = 6'd8;
      end
      crc16mw_pkg::FEED_16: begin
        masked = {16'd0, data_word[15:0]};
        nbits  = 6'd16;
      end
      default: begin
        masked = data_word;
        nbits  = 6'd32;
      end
    endcase
  end

  // Reversal span is clipped to the fed width.
  always_comb begin
    case (reverse_mode)
      crc16mw_pkg::REV_NONE: reversed = masked;
      crc16mw_pkg::REV_BYTE: reversed = crc16mw_pkg::rev_bytes(masked);
      crc16mw_pkg::REV_HALF: begin
        if (feed_width == crc16mw_pkg::FEED_8) begin
          reversed = crc16mw_pkg::rev_bytes(masked);
        end else begin
          reversed = crc16mw_pkg::rev_halves(masked);
        end
      end
      default: begin
        case (feed_width)
          crc16mw_pkg::FEED_8:  reversed = crc16mw_pkg::rev_bytes(masked);
          crc16mw_pkg::FEED_16: reversed = crc16mw_pkg::rev_halves(masked);
          default:              reversed = crc16mw_pkg::rev_word(masked);
        endcase
      end
    endcase
  end

  // Move the fed bits to the top of the word.
  always_comb begin
    case (feed_width)
      crc16mw_pkg::FEED_8:  aligned = {reversed[7:0], 24'd0};
      crc16mw_pkg::FEED_16: aligned = {reversed[15:0], 16'd0};
      default:              aligned = reversed;
    endcase
  end

endmodule

// ===== src/crc16mw_engine.sv =====
// ----------------------------------------------------------------------------
// crc16mw_engine
// Holds the CRC register and runs up to 32 data bits through the
// configured polynomial, MSB first, in one unrolled XOR network.
// ----------------------------------------------------------------------------
module crc16mw_engine (
  input  logic                  clk,
  input  logic                  rst,
  input  crc16mw_pkg::eng_ctl_t ctl,
  input  crc16mw_pkg::data_t    aligned,
  input  logic [5:0]            nbits,
  input  crc16mw_pkg::crc_t     polynomial,
  input  crc16mw_pkg::crc_t     initial_value,
  output crc16mw_pkg::crc_t     crc_next,
  output crc16mw_pkg::crc_t     crc_state
);

  crc16mw_pkg::crc_t crc_reg;
  crc16mw_pkg::crc_t crc_start;

  // A first word restarts from the initial value.
  assign crc_start = ctl.first_item ? initial_value : crc_reg;

  // Bit-serial CRC update, unrolled; steps past the fed width pass through.
  always_comb begin
    crc16mw_pkg::crc_t c;
    logic              fb;
    c = crc_start;
    for (int k = 0; k < crc16mw_pkg::DATA_BITS; k++) begin
      fb = c[crc16mw_pkg::CRC_BITS-1] ^ aligned[crc16mw_pkg::DATA_BITS-1-k];
      if (6'(k) < nbits) begin
        c = {c[crc16mw_pkg::CRC_BITS-2:0], 1'b0} ^ (fb ? polynomial : '0);
      end
    end
    crc_next = c;
  end

  // The register follows every word that leaves the input stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg <= crc16mw_pkg::INIT_RESET;
    end else if (ctl.go) begin
      crc_reg <= crc_next;
    end
  end

  assign crc_state = crc_reg;

endmodule

// ===== src/crc16_unit_mixed_width_feed_top.sv =====
// ----------------------------------------------------------------------------
// crc16_unit_mixed_width_feed_top
// CRC-16 unit fed with 8, 16 or 32-bit words, with input bit reversal,
// frame restart and end-of-frame result with optional output reflection.
//
//   Channel  Handshake               Payload
//   -------  ----------------------  ---------------------------------------
//   input    in_valid / in_ready     data_word, feed_width, reverse_mode,
//                                    first_item, last_item
//   output   out_valid / out_ready   crc_value, crc_is_zero
//   config   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A word is taken into the input register, and when it leaves the input
// stage the CRC engine folds it into the CRC register in one unrolled pass;
// one word per cycle is sustained while the input does not stall. A last
// word loads the output register as it leaves the input stage. Synchronous
// reset restores the CRC-16/MODBUS settings and a CRC register of all ones.
// The input stalls only while a last word waits behind an untaken result.
// ----------------------------------------------------------------------------
module crc16_unit_mixed_width_feed_top (
  input  logic        clk,
  input  logic        rst,
  // Input words
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] data_word,
  input  logic [1:0]  feed_width,
  input  logic [1:0]  reverse_mode,
  input  logic        first_item,
  input  logic        last_item,
  // Results
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] crc_value,
  output logic        crc_is_zero,
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  crc16mw_pkg::crc_t     polynomial;
  crc16mw_pkg::crc_t     initial_value;
  logic                  output_reflect;

  crc16mw_pkg::item_t    item;
  logic                  item_valid;
  logic                  stage_go;

  crc16mw_pkg::data_t    aligned;
  logic [5:0]            nbits;
  crc16mw_pkg::eng_ctl_t eng_ctl;
  crc16mw_pkg::crc_t     crc_next;
  crc16mw_pkg::crc_t     crc_state;
  crc16mw_pkg::crc_t     result_next;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      polynomial     <= crc16mw_pkg::POLY_RESET;
      initial_value  <= crc16mw_pkg::INIT_RESET;
      output_reflect <= crc16mw_pkg::REFL_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        crc16mw_pkg::REG_POLYNOMIAL:     polynomial     <= cfg_data;
        crc16mw_pkg::REG_INITIAL_VALUE:  initial_value  <= cfg_data;
        crc16mw_pkg::REG_OUTPUT_REFLECT: output_reflect <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The input stage moves on unless a last word faces a full output register.
  assign stage_go = item_valid && (!item.last_item || !out_valid || out_ready);
  assign in_ready = !item_valid || stage_go;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= '{data_word:    data_word,
                feed_width:   feed_width,
                reverse_mode: reverse_mode,
                first_item:   first_item,
                last_item:    last_item};
    end
  end

  // Data preparation and CRC update.
  crc16mw_prep u_prep (
    .data_word    (item.data_word),
    .feed_width   (item.feed_width),
    .reverse_mode (item.reverse_mode),
    .aligned      (aligned),
    .nbits        (nbits)
  );

  assign eng_ctl = '{go: stage_go, first_item: item.first_item};

  crc16mw_engine u_engine (
    .clk           (clk),
    .rst           (rst),
    .ctl           (eng_ctl),
    .aligned       (aligned),
    .nbits         (nbits),
    .polynomial    (polynomial),
    .initial_value (initial_value),
    .crc_next      (crc_next),
    .crc_state     (crc_state)
  );

  // Output reflection ahead of the result register.
  assign result_next = output_reflect ? crc16mw_pkg::reflect_crc(crc_next) : crc_next;

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_go && item.last_item) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_go && item.last_item) begin
      crc_value   <= result_next;
      crc_is_zero <= (result_next == '0);
    end
  end

  // A held word in the input stage stays held when it cannot advance.
  a_item_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && !stage_go |=> item_valid && $stable(item))
    else $error("input stage lost a stalled word");

  // A word that is not last never creates a result.
  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    !(stage_go && item.last_item) && (!out_valid || out_ready) |=> !out_valid)
    else $error("result appeared without a last word");

  // The CRC register changes only when a word leaves the input stage.
  a_crc_stable: assert property (@(posedge clk) disable iff (rst)
    !stage_go |=> $stable(crc_state))
    else $error("CRC register changed without a word");

  // The zero flag agrees with the reported value.
  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> crc_is_zero == (crc_value == '0))
    else $error("zero flag disagrees with CRC value");

  // After reset the CRC register holds all ones.
  a_reset_crc: assert property (@(posedge clk)
    $past(rst) |-> crc_state == crc16mw_pkg::INIT_RESET)
    else $error("CRC register not restored by reset");

endmodule
